/* design/tpqrc_pkg.sv */
// Shared constants and the controller-to-datapath command type of the rate control unit.
package tpqrc_pkg;

  localparam int MISS_W  = 40;
  localparam int FRAME_W = 32;
  localparam int BYTES_W = 24;
  localparam int QUANT_W = 13;
  localparam int DELTA_W = 9;
  localparam int RF_W    = 12;
  localparam int SCALE_W = 21;  // reaction factor times gain times 100
  localparam int NUM_W   = 60;  // |miss| times scale stays below 2^60
  localparam int QUO_W   = 8;
  localparam int DIV_STEPS = 8;
  localparam int STEP_W  = 3;

  // Configuration register indexes
  localparam logic REG_CODEC_MODE = 1'b0;
  localparam logic REG_REACTION   = 1'b1;

  localparam logic MODE_MPEG4 = 1'b0;
  localparam logic MODE_H264  = 1'b1;

  localparam logic [RF_W-1:0] RF_RESET = 12'd256;

  // Gain times 100, the hundredths scale folded in
  localparam logic [8:0] GAIN100_MPEG4 = 9'd400;
  localparam logic [8:0] GAIN100_H264  = 9'd200;

  localparam logic [QUO_W-1:0]   DELTA_LIMIT  = 8'd250;
  localparam logic [QUANT_W-1:0] MPEG4_Q_LOW  = 13'd50;
  localparam logic [QUANT_W-1:0] MPEG4_Q_HIGH = 13'd3149;
  localparam logic [QUANT_W-1:0] H264_Q_LOW   = 13'd40;
  localparam logic [QUANT_W-1:0] H264_Q_HIGH  = 13'd5149;

  typedef struct packed {
    logic load;
    logic absval;
    logic mul_lo;
    logic mul_hi;
    logic div_init;
    logic div_step;
    logic finish;
  } tpqrc_cmd_t;

endpackage

/* design/tpqrc_ctrl.sv */
// Sequencer that steps one frame through the datapath and owns the handshakes.
module tpqrc_ctrl import tpqrc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output tpqrc_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_ABS      = 3'd1;
  localparam logic [2:0] ST_MUL_LO   = 3'd2;
  localparam logic [2:0] ST_MUL_HI   = 3'd3;
  localparam logic [2:0] ST_DIV_INIT = 3'd4;
  localparam logic [2:0] ST_DIV      = 3'd5;
  localparam logic [2:0] ST_FINISH   = 3'd6;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              fire_finish;

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  // A result may leave the datapath only once the output register is free
  assign fire_finish = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ABS;
        end
      end
      ST_ABS: begin
        cmd.absval = 1'b1;
        state_nxt  = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fire_finish) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire_finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* design/tpqrc_dp.sv */
// Datapath: running miss, scaled product, restoring divider and quantizer clamp.
module tpqrc_dp import tpqrc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tpqrc_cmd_t                cmd,
  input  logic                      codec_mode,
  input  logic [RF_W-1:0]           reaction_factor,
  input  logic [BYTES_W-1:0]        in_actual_bytes,
  input  logic [BYTES_W-1:0]        in_desired_bytes,
  input  logic [QUANT_W-1:0]        in_planned_quant,
  output logic [QUANT_W-1:0]        out_new_quant,
  output logic signed [DELTA_W-1:0] out_applied_delta,
  output logic signed [MISS_W-1:0]  out_running_miss,
  output logic [FRAME_W-1:0]        out_frame_index
);

  localparam int SUM_W = MISS_W + 2;
  localparam int DVS_W = BYTES_W + 15;  // coded bytes times 256, shifted up seven steps

  localparam logic signed [SUM_W-1:0] MISS_MAX = {3'b000, {(MISS_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] MISS_MIN = {3'b111, {(MISS_W-1){1'b0}}};

  logic signed [MISS_W-1:0] miss_r, miss_nxt;
  logic [FRAME_W-1:0]       frame_r;
  logic [BYTES_W-1:0]       coded_r;
  logic [QUANT_W-1:0]       planned_r;
  logic [SCALE_W-1:0]       scale_r;
  logic [MISS_W-1:0]        mag_r;
  logic                     neg_r, zero_r, sat_r;
  logic [NUM_W-1:0]         num_r;
  logic [DVS_W-1:0]         dvs_r;
  logic [QUO_W-1:0]         quo_r;

  logic signed [BYTES_W:0]  diff;
  logic signed [SUM_W-1:0]  miss_sum;
  logic [8:0]               gain100;
  logic [NUM_W:0]           trial;
  logic [QUO_W-1:0]         qmag;
  logic signed [DELTA_W-1:0] dq;
  logic signed [QUANT_W+1:0] qsum;
  logic [QUANT_W-1:0]       q_lo, q_hi, q_final;

  assign diff     = $signed({1'b0, in_actual_bytes}) - $signed({1'b0, in_desired_bytes});
  assign miss_sum = SUM_W'(miss_r) + SUM_W'(diff);
  assign gain100  = (codec_mode == MODE_H264) ? GAIN100_H264 : GAIN100_MPEG4;

  always_comb begin
    if (miss_sum > MISS_MAX) begin
      miss_nxt = MISS_MAX[MISS_W-1:0];
    end else if (miss_sum < MISS_MIN) begin
      miss_nxt = MISS_MIN[MISS_W-1:0];
    end else begin
      miss_nxt = miss_sum[MISS_W-1:0];
    end
  end

  assign trial = {1'b0, num_r} - (NUM_W+1)'(dvs_r);

  // Zero miss gives no correction; zero coded bytes with a nonzero miss lands in the saturated case
  always_comb begin
    if (zero_r) begin
      qmag = '0;
    end else if (sat_r || (quo_r > DELTA_LIMIT)) begin
      qmag = DELTA_LIMIT;
    end else begin
      qmag = quo_r;
    end
  end

  assign dq   = neg_r ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  assign qsum = $signed({2'b00, planned_r}) + (QUANT_W+2)'(dq);
  assign q_lo = (codec_mode == MODE_H264) ? H264_Q_LOW : MPEG4_Q_LOW;
  assign q_hi = (codec_mode == MODE_H264) ? H264_Q_HIGH : MPEG4_Q_HIGH;

  always_comb begin
    if (qsum > $signed({2'b00, q_hi})) begin
      q_final = q_hi;
    end else if (qsum < $signed({2'b00, q_lo})) begin
      q_final = q_lo;
    end else begin
      q_final = qsum[QUANT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_r  <= '0;
      frame_r <= '0;
    end else begin
      if (cmd.load) begin
        miss_r <= miss_nxt;
      end
      if (cmd.finish) begin
        frame_r <= frame_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      coded_r   <= in_actual_bytes;
      planned_r <= in_planned_quant;
      scale_r   <= SCALE_W'(reaction_factor * gain100);
    end
    if (cmd.absval) begin
      neg_r  <= miss_r[MISS_W-1];
      zero_r <= (miss_r == '0);
      mag_r  <= miss_r[MISS_W-1] ? MISS_W'(-miss_r) : MISS_W'(miss_r);
    end
    if (cmd.mul_lo) begin
      num_r <= NUM_W'(mag_r[31:0] * scale_r);
    end
    if (cmd.mul_hi) begin
      num_r <= num_r + (NUM_W'(mag_r[MISS_W-1:32] * scale_r) << 32);
    end
    if (cmd.div_init) begin
      sat_r <= (num_r >= NUM_W'({coded_r, 16'b0}));
      dvs_r <= {coded_r, 15'b0};
      quo_r <= '0;
    end
    if (cmd.div_step) begin
      if (!trial[NUM_W]) begin
        num_r <= trial[NUM_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        quo_r <= {quo_r[QUO_W-2:0], 1'b0};
      end
      dvs_r <= dvs_r >> 1;
    end
    if (cmd.finish) begin
      out_new_quant     <= q_final;
      out_applied_delta <= dq;
      out_running_miss  <= miss_r;
      out_frame_index   <= frame_r;
    end
  end

endmodule

/* design/two_pass_quantizer_rate_control_unit.sv */
// Top level of the two-pass quantizer rate control unit: registers, sequencer and datapath.
//
//   channel  | signals                                    | transfer
//   ---------+--------------------------------------------+-----------------------
//   in       | actual_bytes, desired_bytes, planned_quant | in_valid & in_ready
//   out      | new_quant, applied_delta, running_miss,    | out_valid & out_ready
//            | frame_index                                |
//   cfg      | cfg_index, cfg_wdata                       | cfg_we
//
// The output register loads at the end of this sequence: the running miss updates at the
// accepting edge, then the magnitude, the product in a low and a high part split at bit
// 32, a divider setup, eight restoring divider steps and a finishing step. Input is
// ready again after the finishing step; a new item is taken only once the last is done.
// Reset clears the running miss, the frame count and the configuration registers to their defaults.
// A result held by a stalled output stalls the next item only at its finishing step.
module two_pass_quantizer_rate_control_unit import tpqrc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [RF_W-1:0]           cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [BYTES_W-1:0]        in_actual_bytes,
  input  logic [BYTES_W-1:0]        in_desired_bytes,
  input  logic [QUANT_W-1:0]        in_planned_quant,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [QUANT_W-1:0]        out_new_quant,
  output logic signed [DELTA_W-1:0] out_applied_delta,
  output logic signed [MISS_W-1:0]  out_running_miss,
  output logic [FRAME_W-1:0]        out_frame_index
);

  logic            codec_mode_r;
  logic [RF_W-1:0] reaction_r;
  tpqrc_cmd_t      cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_mode_r <= MODE_MPEG4;
      reaction_r   <= RF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CODEC_MODE: codec_mode_r <= cfg_wdata[0];
        REG_REACTION:   reaction_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  tpqrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  tpqrc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .codec_mode        (codec_mode_r),
    .reaction_factor   (reaction_r),
    .in_actual_bytes   (in_actual_bytes),
    .in_desired_bytes  (in_desired_bytes),
    .in_planned_quant  (in_planned_quant),
    .out_new_quant     (out_new_quant),
    .out_applied_delta (out_applied_delta),
    .out_running_miss  (out_running_miss),
    .out_frame_index   (out_frame_index)
  );

endmodule
